// ----- rtl/rtss_pkg.sv -----
// Shared types, register codes and fixed-point helpers for the rotozoom texture sampler.
`default_nettype none

package rtss_pkg;

	// Fraction bits of the coefficient and offset registers
	localparam int COEF_FRAC = 16;
	// Width of the coordinate accumulator (two 42-bit products plus an offset)
	localparam int ACC_W = 44;
	// Entries of the queue between the front and the back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
	// Width of a texel store address before the range check
	localparam int ADDR_W = 27;

	// Item operation codes
	typedef enum logic {
		OP_LOAD   = 1'b0,
		OP_SAMPLE = 1'b1
	} op_t;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_CENTER_X = 3'd0,
		REG_CENTER_Y = 3'd1,
		REG_COEF_COS = 3'd2,
		REG_COEF_SIN = 3'd3,
		REG_U_OFFSET = 3'd4,
		REG_V_OFFSET = 3'd5,
		REG_TEX_W    = 3'd6,
		REG_TEX_H    = 3'd7
	} reg_idx_t;

	// One input transaction
	typedef struct packed {
		op_t         operation;
		logic [11:0] texel_index;
		logic [31:0] texel_value;
		logic [11:0] pixel_x;
		logic [11:0] pixel_y;
	} in_item_t;

	// One result transaction
	typedef struct packed {
		logic [11:0] dest_x;
		logic [11:0] dest_y;
		logic [31:0] color;
		logic        write_enable;
	} out_item_t;

	// Configuration register file, held as raw bits
	typedef struct packed {
		logic [15:0] center_x;
		logic [15:0] center_y;
		logic [23:0] coef_cos;
		logic [23:0] coef_sin;
		logic [31:0] u_offset;
		logic [31:0] v_offset;
		logic [12:0] tex_w;
		logic [12:0] tex_h;
	} cfg_t;

	// Classified item as it sits in the queue
	typedef struct packed {
		op_t         kind;
		logic        load_ok;
		logic [11:0] texel_index;
		logic [31:0] texel_value;
		logic [11:0] pixel_x;
		logic [11:0] pixel_y;
	} queue_item_t;

	// Rounded texel coordinate and whether it lies inside [0, lim)
	typedef struct packed {
		logic        ok;
		logic [12:0] idx;
	} coord_t;

	localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (COEF_FRAC - 1);

	// Truncate toward zero (half already added) and check against the limit
	function automatic coord_t round_check(logic signed [ACC_W-1:0] t, logic [12:0] lim);
		logic signed [ACC_W-1:0] hi;
		coord_t                  r;
		hi = t >>> COEF_FRAC;
		if (!t[ACC_W-1]) begin
			r.ok  = (hi[ACC_W-1:13] == '0) && (hi[12:0] < lim);
			r.idx = hi[12:0];
		end else begin
			// values in (-1, 0) truncate to column zero
			r.ok  = (&hi) && (t[COEF_FRAC-1:0] != '0) && (lim != 13'd0);
			r.idx = 13'd0;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/rtss_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rtss_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write and read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/rtss_front.sv -----
// Front end: accept input transactions, classify them and queue them for the back end.
`default_nettype none

module rtss_front
	import rtss_pkg::*;
#(
	parameter int TEX_WORDS = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire in_item_t    item,
	output logic             q_valid,
	input  wire logic        q_take,
	output queue_item_t      q_item
);

	queue_item_t         slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                push;
	logic                pop;
	queue_item_t         classified;

	assign item_stall = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign push       = item_valid && !item_stall;
	assign q_valid    = (count_q != '0);
	assign pop        = q_take && q_valid;
	assign q_item     = slot_q[rd_ptr_q];

	// Classify: flag loads that fall past the store
	always_comb begin
		classified.kind        = item.operation;
		classified.load_ok     = (32'(item.texel_index) < 32'(TEX_WORDS));
		classified.texel_index = item.texel_index;
		classified.texel_value = item.texel_value;
		classified.pixel_x     = item.pixel_x;
		classified.pixel_y     = item.pixel_y;
	end

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= classified;
		end
	end

	// Queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue fill count beyond depth");

	a_take_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_take |-> (count_q != '0) || !q_valid)
		else $error("queue taken while empty");

	a_push_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + QCNT_W'(1)))
		else $error("queue count missed a push");
`endif

endmodule

`default_nettype wire

// ----- rtl/rtss_back.sv -----
// Back end: coordinate pipeline, texel store access and output register.
`default_nettype none

module rtss_back
	import rtss_pkg::*;
#(
	parameter int TEX_WORDS = 4096
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire cfg_t         cfg,
	input  wire logic         q_valid,
	output logic              q_take,
	input  wire queue_item_t  q_item,
	output logic              result_valid,
	input  wire logic         result_stall,
	output out_item_t         result
);

	localparam int AW = $clog2(TEX_WORDS);

	logic                    adv;
	logic signed [23:0]      cc;
	logic signed [23:0]      cs;
	logic signed [ACC_W-1:0] uo;
	logic signed [ACC_W-1:0] vo;
	logic signed [17:0]      cx;
	logic signed [17:0]      cy;

	// stage 1: offsets from centre
	logic                    valid_s1;
	queue_item_t             item_s1;
	logic signed [17:0]      dx_s1;
	logic signed [17:0]      dy_s1;
	// stage 2: products
	logic                    valid_s2;
	queue_item_t             item_s2;
	logic signed [41:0]      p_xc_s2;
	logic signed [41:0]      p_ys_s2;
	logic signed [41:0]      p_xs_s2;
	logic signed [41:0]      p_yc_s2;
	// stage 3: sums
	logic                    valid_s3;
	queue_item_t             item_s3;
	logic signed [ACC_W-1:0] u_s3;
	logic signed [ACC_W-1:0] v_s3;
	// stage 4: rounded coordinates
	logic                    valid_s4;
	queue_item_t             item_s4;
	coord_t                  cu_s4;
	coord_t                  cv_s4;
	coord_t                  cu;
	coord_t                  cv;
	// stage 5: store address
	logic                    valid_s5;
	queue_item_t             item_s5;
	logic [ADDR_W-1:0]       addr_s5;
	logic                    hit_s5;
	// stage 6: store read data
	logic                    valid_s6;
	op_t                     kind_s6;
	logic [11:0]             px_s6;
	logic [11:0]             py_s6;
	logic                    hit_s6;
	// output register
	logic                    result_valid_q;
	out_item_t               result_q;

	logic                    in_store;
	logic                    ram_we;
	logic [31:0]             ram_rdata;

	assign cc = $signed(cfg.coef_cos);
	assign cs = $signed(cfg.coef_sin);
	assign uo = ACC_W'($signed(cfg.u_offset));
	assign vo = ACC_W'($signed(cfg.v_offset));
	assign cx = {{2{cfg.center_x[15]}}, cfg.center_x};
	assign cy = {{2{cfg.center_y[15]}}, cfg.center_y};

	// Advance the whole pipeline unless a finished result is held
	assign adv    = !result_valid_q || !result_stall;
	assign q_take = adv && q_valid;

	assign cu = round_check(u_s3, cfg.tex_w);
	assign cv = round_check(v_s3, cfg.tex_h);

	assign in_store = (32'(addr_s5) < 32'(TEX_WORDS));
	assign ram_we   = adv && valid_s5 && (item_s5.kind == OP_LOAD) && hit_s5;

	// Pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			valid_s2       <= 1'b0;
			valid_s3       <= 1'b0;
			valid_s4       <= 1'b0;
			valid_s5       <= 1'b0;
			valid_s6       <= 1'b0;
			result_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1       <= q_valid;
			valid_s2       <= valid_s1;
			valid_s3       <= valid_s2;
			valid_s4       <= valid_s3;
			valid_s5       <= valid_s4;
			valid_s6       <= valid_s5;
			result_valid_q <= valid_s6 && (kind_s6 == OP_SAMPLE);
		end
	end

	// Pipeline payload
	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1  <= q_item;
			dx_s1    <= $signed({6'd0, q_item.pixel_x}) - cx;
			dy_s1    <= $signed({6'd0, q_item.pixel_y}) - cy;

			item_s2  <= item_s1;
			p_xc_s2  <= dx_s1 * cc;
			p_ys_s2  <= dy_s1 * cs;
			p_xs_s2  <= dx_s1 * cs;
			p_yc_s2  <= dy_s1 * cc;

			item_s3  <= item_s2;
			u_s3     <= ACC_W'(p_xc_s2) + ACC_W'(p_ys_s2) + uo + HALF;
			v_s3     <= ACC_W'(p_yc_s2) - ACC_W'(p_xs_s2) + vo + HALF;

			item_s4  <= item_s3;
			cu_s4    <= cu;
			cv_s4    <= cv;

			item_s5  <= item_s4;
			if (item_s4.kind == OP_LOAD) begin
				addr_s5 <= ADDR_W'(item_s4.texel_index);
				hit_s5  <= item_s4.load_ok;
			end else begin
				addr_s5 <= ADDR_W'(cv_s4.idx) * ADDR_W'(cfg.tex_w) + ADDR_W'(cu_s4.idx);
				hit_s5  <= cu_s4.ok && cv_s4.ok;
			end

			kind_s6  <= item_s5.kind;
			px_s6    <= item_s5.pixel_x;
			py_s6    <= item_s5.pixel_y;
			hit_s6   <= hit_s5 && in_store;

			result_q.dest_x       <= px_s6;
			result_q.dest_y       <= py_s6;
			result_q.color        <= hit_s6 ? ram_rdata : 32'd0;
			result_q.write_enable <= hit_s6 && (ram_rdata[31:24] != 8'd0);
		end
	end

	// Texel store: loads write and samples read at the same stage, keeping order
	rtss_ram #(
		.WIDTH (32),
		.DEPTH (TEX_WORDS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_s5[AW-1:0]),
		.wdata (item_s5.texel_value),
		.re    (adv),
		.raddr (addr_s5[AW-1:0]),
		.rdata (ram_rdata)
	);

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTHESIS
	a_we_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.write_enable) |-> (result.color[31:24] != 8'd0))
		else $error("write enable with zero alpha");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=>
			($stable(valid_s5) && (!valid_s5 || $stable(addr_s5))))
		else $error("pipeline moved while result held");

	a_result_from_sample: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> ($past(valid_s6) && ($past(kind_s6) == OP_SAMPLE)))
		else $error("result without a sample behind it");
`endif

endmodule

`default_nettype wire

// ----- rtl/rotozoom_texture_sampler.sv -----
// Top level of the rotozoom texture sampler: configuration registers, front and back ends.
//
// Usage: the item channel (item_valid, item_stall, item) takes load and sample
// transactions. A load writes one ARGB texel into the texture store and gives
// no result; a sample gives one result on the result channel (result_valid,
// result_stall, result) carrying the destination pixel, the texel colour and
// a write enable for inside texels with nonzero alpha.
// Throughput is one transaction per clock while no finished result is held by result_stall.
// An accepted sample passes through the input queue, then six pipeline stages
// (offsets, four multipliers, sums, rounding, address multiply-add, store read)
// and the output register.
// When result_stall holds a finished result, the whole back pipeline freezes;
// the four-entry input queue keeps taking transactions until it fills, then
// raises item_stall.
// Reset clears the queue and pipeline and restores the register defaults;
// the texture store holds nothing meaningful until texels are loaded. Write
// configuration (cfg_we, cfg_index, cfg_data) only while the block is idle.
`default_nettype none

module rotozoom_texture_sampler
	import rtss_pkg::*;
#(
	parameter int TEX_WORDS = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire in_item_t    item,
	output logic             result_valid,
	input  wire logic        result_stall,
	output out_item_t        result,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	cfg_t        cfg_q;
	logic        q_valid;
	logic        q_take;
	queue_item_t q_item;

	// Configuration register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_x <= 16'd0;
			cfg_q.center_y <= 16'd0;
			cfg_q.coef_cos <= 24'd65536;
			cfg_q.coef_sin <= 24'd0;
			cfg_q.u_offset <= 32'd0;
			cfg_q.v_offset <= 32'd0;
			cfg_q.tex_w    <= 13'd1;
			cfg_q.tex_h    <= 13'd1;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_CENTER_X: cfg_q.center_x <= cfg_data[15:0];
				REG_CENTER_Y: cfg_q.center_y <= cfg_data[15:0];
				REG_COEF_COS: cfg_q.coef_cos <= cfg_data[23:0];
				REG_COEF_SIN: cfg_q.coef_sin <= cfg_data[23:0];
				REG_U_OFFSET: cfg_q.u_offset <= cfg_data;
				REG_V_OFFSET: cfg_q.v_offset <= cfg_data;
				REG_TEX_W:    cfg_q.tex_w    <= cfg_data[12:0];
				REG_TEX_H:    cfg_q.tex_h    <= cfg_data[12:0];
				default: begin
				end
			endcase
		end
	end

	rtss_front #(
		.TEX_WORDS (TEX_WORDS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.q_valid    (q_valid),
		.q_take     (q_take),
		.q_item     (q_item)
	);

	rtss_back #(
		.TEX_WORDS (TEX_WORDS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_valid      (q_valid),
		.q_take       (q_take),
		.q_item       (q_item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the rotozoom texture sampler: directed and random load/sample traffic.
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import rtss_pkg::*;

	localparam int TEX_WORDS     = 4096;
	// cycles without any transaction before the run is declared hung; it
	// must exceed the slowest legal stretch (78% stalls or gaps)
	localparam int STALL_LIMIT   = 2000;
	// covers the pipeline latency plus margin for loads still in flight
	localparam int SETTLE_CYCLES = 12;
	localparam int RANDOM_PHASES = 9;
	localparam int PHASE_ITEMS   = 58;
	localparam int NEAR_RADIUS   = 48;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        item_valid   = 1'b0;
	logic        item_stall;
	in_item_t    item         = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	out_item_t   result;
	logic        cfg_we       = 1'b0;
	logic [2:0]  cfg_index    = '0;
	logic [31:0] cfg_data     = '0;

	// register shadow, starting from the reset values
	cfg_t cfg_now = '{center_x: 16'd0, center_y: 16'd0, coef_cos: 24'd65536, coef_sin: 24'd0,
		u_offset: 32'd0, v_offset: 32'd0, tex_w: 13'd1, tex_h: 13'd1};

	logic [31:0] texel_mem [TEX_WORDS];
	bit          texel_loaded [TEX_WORDS];
	in_item_t    pending_items [$];
	out_item_t   expected_pixels [$];

	int send_idle_pct   = 0;
	int recv_stall_pct  = 0;
	int items_queued    = 0;
	int items_taken     = 0;
	int samples_checked = 0;
	int texels_drawn    = 0;
	int mismatches      = 0;
	int settings_used   = 1;
	int idle_cycles     = 0;

	rotozoom_texture_sampler #(
		.TEX_WORDS(TEX_WORDS)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #10 clk = ~clk;

	// Add one half, then truncate toward zero
	function automatic longint nearest_texel(longint t);
		longint h;
		h = t + (longint'(1) <<< (COEF_FRAC - 1));
		if (h >= 0)
			return h >>> COEF_FRAC;
		return -((-h) >>> COEF_FRAC);
	endfunction

	// Store address hit by a destination pixel, or -1 when outside texture or store
	function automatic longint texel_addr(logic [11:0] px, logic [11:0] py);
		longint dx, dy, cc, cs, u, v, ix, iy, tw, th;
		dx = longint'(px) - longint'($signed(cfg_now.center_x));
		dy = longint'(py) - longint'($signed(cfg_now.center_y));
		cc = longint'($signed(cfg_now.coef_cos));
		cs = longint'($signed(cfg_now.coef_sin));
		u  = dx * cc + dy * cs + longint'($signed(cfg_now.u_offset));
		v  = dy * cc - dx * cs + longint'($signed(cfg_now.v_offset));
		ix = nearest_texel(u);
		iy = nearest_texel(v);
		tw = longint'(cfg_now.tex_w);
		th = longint'(cfg_now.tex_h);
		if (ix >= 0 && ix < tw && iy >= 0 && iy < th && iy * tw + ix < TEX_WORDS)
			return iy * tw + ix;
		return -1;
	endfunction

	// Pixel the block should emit for one sample
	function automatic out_item_t sampled_pixel(in_item_t it);
		out_item_t r;
		longint    a;
		a              = texel_addr(it.pixel_x, it.pixel_y);
		r.dest_x       = it.pixel_x;
		r.dest_y       = it.pixel_y;
		r.color        = (a >= 0) ? texel_mem[a] : 32'd0;
		r.write_enable = |r.color[31:24];
		return r;
	endfunction

	function automatic logic [31:0] random_texel();
		if ($urandom_range(0, 5) == 0)
			return {8'h00, 24'($urandom)};
		return $urandom;
	endfunction

	function automatic cfg_t random_settings();
		cfg_t c;
		int   tw, th;
		tw = $urandom_range(1, 64);
		th = $urandom_range(1, 64);
		if ($urandom_range(0, 3) == 0) begin
			// wide textures, sometimes running past the store
			tw = $urandom_range(1, 4096);
			th = $urandom_range(1, 4096 / tw + 1);
		end
		c.center_x = 16'($urandom_range(64, 4031));
		c.center_y = 16'($urandom_range(64, 4031));
		c.coef_cos = 24'(int'($urandom_range(0, 196608)) - 98304);
		c.coef_sin = 24'(int'($urandom_range(0, 196608)) - 98304);
		c.u_offset = 32'(tw * 32768 + int'($urandom_range(0, 65535)) - 32768);
		c.v_offset = 32'(th * 32768 + int'($urandom_range(0, 65535)) - 32768);
		c.tex_w    = 13'(tw);
		c.tex_h    = 13'(th);
		return c;
	endfunction

	task automatic queue_load(int idx, logic [31:0] val);
		in_item_t it;
		it.operation   = OP_LOAD;
		it.texel_index = 12'(idx);
		it.texel_value = val;
		it.pixel_x     = 12'($urandom);
		it.pixel_y     = 12'($urandom);
		pending_items.push_back(it);
		texel_loaded[12'(idx)] = 1'b1;
		items_queued++;
	endtask

	// Queue a sample, loading its texel first if it was never written
	task automatic queue_sample(logic [11:0] px, logic [11:0] py);
		in_item_t it;
		longint   a;
		a = texel_addr(px, py);
		if (a >= 0 && !texel_loaded[a])
			queue_load(int'(a), random_texel());
		it.operation   = OP_SAMPLE;
		it.texel_index = 12'($urandom);
		it.texel_value = $urandom;
		it.pixel_x     = px;
		it.pixel_y     = py;
		pending_items.push_back(it);
		items_queued++;
	endtask

	task automatic set_idling(int mode);
		case (mode)
			0: begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
			1: begin
				send_idle_pct  = 78;
				recv_stall_pct = 0;
			end
			2: begin
				send_idle_pct  = 0;
				recv_stall_pct = 78;
			end
			default: begin
				send_idle_pct  = 34;
				recv_stall_pct = 34;
			end
		endcase
	endtask

	// Wait until every transaction is in and every result out, then let the pipe empty
	task automatic settle();
		do
			@(negedge clk);
		while (pending_items.size() != 0 || item_valid || expected_pixels.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Program all eight registers; only called while the block is idle
	task automatic write_settings(cfg_t next);
		reg_idx_t r;
		cfg_now = next;
		for (int i = 0; i < 8; i++) begin
			r = reg_idx_t'(i);
			@(posedge clk);
			cfg_we    <= 1'b1;
			cfg_index <= r;
			case (r)
				REG_CENTER_X: cfg_data <= 32'($signed(next.center_x));
				REG_CENTER_Y: cfg_data <= 32'($signed(next.center_y));
				REG_COEF_COS: cfg_data <= 32'($signed(next.coef_cos));
				REG_COEF_SIN: cfg_data <= 32'($signed(next.coef_sin));
				REG_U_OFFSET: cfg_data <= next.u_offset;
				REG_V_OFFSET: cfg_data <= next.v_offset;
				REG_TEX_W:    cfg_data <= 32'(next.tex_w);
				REG_TEX_H:    cfg_data <= 32'(next.tex_h);
				default:      cfg_data <= '0;
			endcase
		end
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		set_idling(settings_used % 4);
		settings_used++;
	endtask

	// Driver: present queued transactions, update the prediction on acceptance
	always @(posedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			if (item_valid && !item_stall) begin
				if (item.operation == OP_LOAD) begin
					texel_mem[item.texel_index] = item.texel_value;
				end else begin
					expected_pixels.push_back(sampled_pixel(item));
				end
				items_taken++;
			end
			if (!item_valid || !item_stall) begin
				if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					item       <= pending_items.pop_front();
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each accepted result against the oldest prediction
	always @(posedge clk) begin : watch_results
		out_item_t want;
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_pixels.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected result x=%0d y=%0d color=%h we=%b", $time,
							result.dest_x, result.dest_y, result.color, result.write_enable);
				end else begin
					want = expected_pixels.pop_front();
					samples_checked++;
					if (want.write_enable)
						texels_drawn++;
					if (result.dest_x !== want.dest_x || result.dest_y !== want.dest_y ||
						result.color !== want.color ||
						result.write_enable !== want.write_enable) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: mismatch, expected x=%0d y=%0d color=%h we=%b, got x=%0d y=%0d color=%h we=%b",
								$time, want.dest_x, want.dest_y, want.color, want.write_enable,
								result.dest_x, result.dest_y, result.color, result.write_enable);
					end
				end
			end
			result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall) || cfg_we) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("rotozoom_texture_sampler test failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		cfg_t c;
		int   start, pick, idx, span, px, py, cx, cy;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: 1x1 texture, identity mapping
		set_idling(0);
		queue_load(0, 32'h80FF_00FF);
		queue_sample(12'd0, 12'd0);
		queue_sample(12'd4095, 12'd4095);
		queue_sample(12'd1, 12'd0);
		queue_load(0, 32'h00AB_CDEF);
		queue_sample(12'd0, 12'd0);
		queue_load(4095, 32'hFFFF_FFFF);
		queue_load(2048, 32'h7F12_3456);
		settle();

		// largest texture: rows past the first run off the end of the store
		c = '{center_x: 16'd0, center_y: 16'd0, coef_cos: 24'd65536, coef_sin: 24'd0,
			u_offset: 32'd0, v_offset: 32'd0, tex_w: 13'd4096, tex_h: 13'd4096};
		write_settings(c);
		queue_sample(12'd4095, 12'd0);
		queue_sample(12'd2048, 12'd0);
		queue_sample(12'd0, 12'd1);
		queue_sample(12'd4095, 12'd4095);
		settle();

		// coordinates just below zero round onto texel zero, a full step below does not
		c = '{center_x: 16'd0, center_y: 16'd0, coef_cos: 24'd65536, coef_sin: 24'd0,
			u_offset: -32'sd98303, v_offset: -32'sd98304, tex_w: 13'd2, tex_h: 13'd2};
		write_settings(c);
		queue_sample(12'd0, 12'd0);
		queue_sample(12'd0, 12'd1);
		queue_sample(12'd1, 12'd1);
		queue_sample(12'd1, 12'd2);
		queue_sample(12'd3, 12'd2);
		settle();

		// register extremes, with zero height and then zero width
		c = '{center_x: 16'h8000, center_y: 16'h7FFF, coef_cos: 24'h80_0000,
			coef_sin: 24'h7F_FFFF, u_offset: 32'h7FFF_FFFF, v_offset: 32'h8000_0000,
			tex_w: 13'd8191, tex_h: 13'd0};
		for (int k = 0; k < 2; k++) begin
			write_settings(c);
			queue_sample(12'd0, 12'd0);
			queue_sample(12'd4095, 12'd4095);
			queue_sample(12'd4095, 12'd0);
			queue_sample(12'd0, 12'd4095);
			settle();
			c = '{center_x: 16'h7FFF, center_y: 16'h8000, coef_cos: 24'h7F_FFFF,
				coef_sin: 24'h80_0000, u_offset: 32'h8000_0000, v_offset: 32'h7FFF_FFFF,
				tex_w: 13'd0, tex_h: 13'd8191};
		end

		// zero coefficients: every pixel lands on the last store word
		c = '{center_x: 16'd0, center_y: 16'd0, coef_cos: 24'd0, coef_sin: 24'd0,
			u_offset: 32'h0FFF_0000, v_offset: 32'd0, tex_w: 13'd4096, tex_h: 13'd1};
		write_settings(c);
		queue_sample(12'd0, 12'd0);
		queue_sample(12'd4095, 12'd4095);
		settle();

		// random rotations and scales, mostly sampling around the sprite centre
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			write_settings(random_settings());
			cx    = int'($signed(cfg_now.center_x));
			cy    = int'($signed(cfg_now.center_y));
			span  = int'(cfg_now.tex_w) * int'(cfg_now.tex_h);
			start = items_queued;
			while (items_queued - start < PHASE_ITEMS) begin
				pick = $urandom_range(0, 99);
				if (pick < 20) begin
					if (pick < 4 || span > TEX_WORDS)
						idx = $urandom_range(0, TEX_WORDS - 1);
					else
						idx = $urandom_range(0, span - 1);
					queue_load(idx, random_texel());
				end else if (pick < 88) begin
					px = cx + int'($urandom_range(0, 2 * NEAR_RADIUS)) - NEAR_RADIUS;
					py = cy + int'($urandom_range(0, 2 * NEAR_RADIUS)) - NEAR_RADIUS;
					px = (px < 0) ? 0 : (px > 4095) ? 4095 : px;
					py = (py < 0) ? 0 : (py > 4095) ? 4095 : py;
					queue_sample(12'(px), 12'(py));
				end else begin
					queue_sample(12'($urandom), 12'($urandom));
				end
			end
			settle();
		end

		mismatches += expected_pixels.size();
		$display("Ran %0d transactions under %0d register settings; %0d samples checked.",
			items_taken, settings_used, samples_checked);
		$display("%0d samples drew a texel, %0d were outside, past the store or transparent.",
			texels_drawn, samples_checked - texels_drawn);
		if (mismatches == 0) begin
			$display("rotozoom_texture_sampler test passed");
		end else begin
			$display("rotozoom_texture_sampler test failed");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/rtss_pkg.sv
rtl/rtss_ram.sv
rtl/rtss_front.sv
rtl/rtss_back.sv
rtl/rotozoom_texture_sampler.sv
tb/sv/testbench.sv
